### src/http_header_field_splitter_top_assert.svh
// Assertion macros for the header field splitter checker.
`ifndef HTTP_HEADER_FIELD_SPLITTER_TOP_ASSERT_SVH
`define HTTP_HEADER_FIELD_SPLITTER_TOP_ASSERT_SVH

// Property checked on every clock outside reset.
`define HHFS_ASSERT(lbl, pr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pr) else $error(msg);

// Property checked in the cycle after a stalled result request.
`define HHFS_ASSERT_HOLD(lbl, pr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (out_valid && out_stall) |=> pr) else $error(msg);

`endif

### src/hhfs_pkg.sv
`timescale 1ns / 1ps

package hhfs_pkg;

    localparam int unsigned MAX_HEADER_BYTES = 65536;
    localparam int unsigned OFFSET_W = 16;
    localparam logic [OFFSET_W-1:0] OFFSET_LIMIT =
        (MAX_HEADER_BYTES < 65535) ? OFFSET_W'(MAX_HEADER_BYTES) : OFFSET_W'(65535);

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    typedef enum logic [2:0] {
        ST_FIELD     = 3'd0,
        ST_HDR_END   = 3'd1,
        ST_NO_COLON  = 3'd2,
        ST_EMPTY_KEY = 3'd3,
        ST_NO_END    = 3'd4,
        ST_TOO_LONG  = 3'd5
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [OFFSET_W-1:0] key_begin;
        logic [OFFSET_W-1:0] key_end;
        logic [OFFSET_W-1:0] value_begin;
        logic [OFFSET_W-1:0] value_end;
        logic [OFFSET_W-1:0] next_offset;
        logic                last_result;
    } res_t;

    typedef struct packed {
        logic a_valid;
        logic b_valid;
    } push_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                   (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

endpackage

### src/hhfs_parse.sv
`timescale 1ns / 1ps

module hhfs_parse
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          first_byte,
    input  logic                          last_byte,
    input  logic                          room,
    output hhfs_pkg::push_t               push,
    output hhfs_pkg::res_t                res_a,
    output hhfs_pkg::res_t                res_b
);

    typedef enum logic [2:0] {
        PH_KEY   = 3'b001,
        PH_VALUE = 3'b010,
        PH_DONE  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [hhfs_pkg::OFFSET_W-1:0] offset;
        phase_t                        phase;
        logic                          cr_pending;
        logic                          line_is_empty;
        logic [hhfs_pkg::OFFSET_W-1:0] key_first;
        logic [hhfs_pkg::OFFSET_W-1:0] key_stop;
        logic                          key_seen;
        logic [hhfs_pkg::OFFSET_W-1:0] value_first;
        logic [hhfs_pkg::OFFSET_W-1:0] value_stop;
        logic                          value_seen;
    } pstate_t;

    function automatic pstate_t clear_line(input pstate_t s);
        pstate_t r;
        r               = s;
        r.line_is_empty = 1'b1;
        r.cr_pending    = 1'b0;
        r.phase         = PH_KEY;
        r.key_first     = '0;
        r.key_stop      = '0;
        r.key_seen      = 1'b0;
        r.value_first   = '0;
        r.value_stop    = '0;
        r.value_seen    = 1'b0;
        return r;
    endfunction

    function automatic pstate_t reset_state();
        pstate_t r;
        r       = clear_line('0);
        r.phase = PH_DONE;
        return r;
    endfunction

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        first_reg;
    logic        last_reg;
    logic        consume;
    logic        accept;
    pstate_t     st_reg;
    pstate_t     st_next;
    pstate_t     nx;
    logic        a_v;
    logic        b_v;
    logic [hhfs_pkg::OFFSET_W-1:0] p;
    logic [hhfs_pkg::OFFSET_W-1:0] p1;

    assign consume  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
        end
    end

    always_comb
    begin
        nx    = st_reg;
        a_v   = 1'b0;
        b_v   = 1'b0;
        res_a = '0;
        res_b = '0;
        if (first_reg)
        begin
            nx        = clear_line(st_reg);
            nx.offset = '0;
        end
        p  = nx.offset;
        p1 = p + hhfs_pkg::OFFSET_W'(1);
        if (nx.phase != PH_DONE)
        begin
            if (p >= hhfs_pkg::OFFSET_LIMIT)
            begin
                nx.phase          = PH_DONE;
                a_v               = 1'b1;
                res_a.status      = hhfs_pkg::ST_TOO_LONG;
                res_a.next_offset = p;
            end
            else
            begin
                nx.offset = p1;
                if (nx.cr_pending && byte_reg == hhfs_pkg::CHAR_LF)
                begin
                    nx.cr_pending     = 1'b0;
                    a_v               = 1'b1;
                    res_a.next_offset = p1;
                    priority if (nx.line_is_empty)
                    begin
                        res_a.status = hhfs_pkg::ST_HDR_END;
                        nx.phase     = PH_DONE;
                    end
                    else if (nx.phase == PH_KEY)
                    begin
                        res_a.status = hhfs_pkg::ST_NO_COLON;
                        nx.phase     = PH_DONE;
                    end
                    else if (!nx.key_seen)
                    begin
                        res_a.status = hhfs_pkg::ST_EMPTY_KEY;
                        nx.phase     = PH_DONE;
                    end
                    else
                    begin
                        res_a.status      = hhfs_pkg::ST_FIELD;
                        res_a.key_begin   = nx.key_first;
                        res_a.key_end     = nx.key_stop;
                        res_a.value_begin = nx.value_first;
                        res_a.value_end   = nx.value_stop;
                        nx                = clear_line(nx);
                    end
                end
                else
                begin
                    // a held CR without LF turns into line content
                    if (nx.cr_pending)
                    begin
                        nx.line_is_empty = 1'b0;
                    end
                    nx.cr_pending = (byte_reg == hhfs_pkg::CHAR_CR);
                    if (byte_reg != hhfs_pkg::CHAR_CR)
                    begin
                        nx.line_is_empty = 1'b0;
                        unique case (nx.phase)
                            PH_KEY:
                            begin
                                if (byte_reg == hhfs_pkg::CHAR_COLON)
                                begin
                                    nx.phase       = PH_VALUE;
                                    nx.value_first = p1;
                                    nx.value_stop  = p1;
                                    nx.value_seen  = 1'b0;
                                end
                                else if (!hhfs_pkg::is_blank(byte_reg))
                                begin
                                    if (!nx.key_seen)
                                    begin
                                        nx.key_first = p;
                                        nx.key_seen  = 1'b1;
                                    end
                                    nx.key_stop = p1;
                                end
                            end
                            PH_VALUE:
                            begin
                                if (!hhfs_pkg::is_blank(byte_reg))
                                begin
                                    if (!nx.value_seen)
                                    begin
                                        nx.value_first = p;
                                        nx.value_seen  = 1'b1;
                                    end
                                    nx.value_stop = p1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                if (last_reg && nx.phase != PH_DONE)
                begin
                    nx.phase          = PH_DONE;
                    b_v               = 1'b1;
                    res_b.status      = hhfs_pkg::ST_NO_END;
                    res_b.next_offset = p1;
                end
            end
        end
        res_a.last_result = !b_v;
        res_b.last_result = 1'b1;
        push.a_valid      = consume && a_v;
        push.b_valid      = consume && b_v;
        st_next           = consume ? nx : st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= reset_state();
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

### src/hhfs_outq.sv
`timescale 1ns / 1ps

module hhfs_outq
(
    input  logic            clk,
    input  logic            rst_n,
    input  hhfs_pkg::push_t push,
    input  hhfs_pkg::res_t  res_a,
    input  hhfs_pkg::res_t  res_b,
    output logic            room,
    output logic            out_valid,
    input  logic            out_stall,
    output hhfs_pkg::res_t  res_out
);

    hhfs_pkg::res_t                  mem [hhfs_pkg::QUEUE_DEPTH];
    logic [hhfs_pkg::QPTR_W-1:0]     head_reg;
    logic [hhfs_pkg::QPTR_W-1:0]     head_next;
    logic [hhfs_pkg::QPTR_W-1:0]     tail_reg;
    logic [hhfs_pkg::QPTR_W-1:0]     tail_next;
    logic [hhfs_pkg::QPTR_W-1:0]     wr_b_idx;
    logic [hhfs_pkg::QCNT_W-1:0]     count_reg;
    logic [hhfs_pkg::QCNT_W-1:0]     count_next;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (count_reg <= hhfs_pkg::QCNT_W'(hhfs_pkg::QUEUE_DEPTH - 2));
    assign res_out   = mem[head_reg];
    assign wr_b_idx  = tail_reg + hhfs_pkg::QPTR_W'(push.a_valid);
    assign tail_next = tail_reg + hhfs_pkg::QPTR_W'(push.a_valid)
                                + hhfs_pkg::QPTR_W'(push.b_valid);
    assign head_next = head_reg + hhfs_pkg::QPTR_W'(pop);
    assign count_next = count_reg + hhfs_pkg::QCNT_W'(push.a_valid)
                                  + hhfs_pkg::QCNT_W'(push.b_valid)
                                  - hhfs_pkg::QCNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
        begin
            mem[tail_reg] <= res_a;
        end
        if (push.b_valid)
        begin
            mem[wr_b_idx] <= res_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/http_header_field_splitter_top.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// input     in_valid / in_stall  data_byte, first_byte, last_byte
// output    out_valid/ out_stall status, key_begin, key_end, value_begin, value_end,
//                                next_offset, last_result
//
// One byte a cycle while in_stall is low: a byte is parsed from the input register and is
// consumed once the queue has room. Its results are written to the queue when the byte is
// consumed and then show on the output; a byte gives 0 to 2 results.
// Results drain from a four-entry queue, one per cycle while out_stall is low; a byte held
// in the input register stalls the input while the queue cannot take two more results.
// rst_n clears the control state; parsing then waits for a byte with first_byte set.

module http_header_field_splitter_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] key_begin,
    output logic [15:0] key_end,
    output logic [15:0] value_begin,
    output logic [15:0] value_end,
    output logic [15:0] next_offset,
    output logic        last_result
);

    hhfs_pkg::push_t push;
    hhfs_pkg::res_t  res_a;
    hhfs_pkg::res_t  res_b;
    hhfs_pkg::res_t  res_out;
    logic            room;

    hhfs_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .last_byte  (last_byte),
        .room       (room),
        .push       (push),
        .res_a      (res_a),
        .res_b      (res_b)
    );

    hhfs_outq u_outq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_a     (res_a),
        .res_b     (res_b),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_out   (res_out)
    );

    assign status      = res_out.status;
    assign key_begin   = res_out.key_begin;
    assign key_end     = res_out.key_end;
    assign value_begin = res_out.value_begin;
    assign value_end   = res_out.value_end;
    assign next_offset = res_out.next_offset;
    assign last_result = res_out.last_result;

endmodule

### src/hhfs_checker.sv
`timescale 1ns / 1ps
`include "http_header_field_splitter_top_assert.svh"

module hhfs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [15:0] key_begin,
    input logic [15:0] key_end,
    input logic [15:0] value_begin,
    input logic [15:0] value_end,
    input logic [15:0] next_offset,
    input logic        last_result
);

    logic        is_field;
    logic        offsets_zero;
    logic        field_ordered;
    logic [83:0] res_bits;

    assign is_field      = (status == hhfs_pkg::ST_FIELD);
    assign offsets_zero  = (key_begin == 16'd0) && (key_end == 16'd0) &&
                           (value_begin == 16'd0) && (value_end == 16'd0);
    assign field_ordered = (key_begin < key_end) && (key_end <= value_begin) &&
                           (value_begin <= value_end) && (value_end < next_offset);
    assign res_bits      = {status, key_begin, key_end, value_begin, value_end,
                            next_offset, last_result};

    `HHFS_ASSERT_HOLD(a_out_hold, out_valid, "result request dropped while stalled")
    `HHFS_ASSERT_HOLD(a_out_stable, $stable(res_bits), "stalled result changed")
    `HHFS_ASSERT(a_nonfield_zero, (out_valid && !is_field) |-> offsets_zero, "offsets on non-field")
    `HHFS_ASSERT(a_nonfield_last, (out_valid && !is_field) |-> last_result, "terminal not last")
    `HHFS_ASSERT(a_field_order, (out_valid && is_field) |-> field_ordered, "field offsets out of order")

endmodule

bind http_header_field_splitter_top hhfs_checker u_hhfs_checker (.*);
